FILE: sv/positional_array_list_assert.svh
// Assertion macros used by the port-level checker of the positional array list.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define PAL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define PAL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/pal_pkg.sv
// Shared types and constants of the positional array list.
package pal_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int MODE_W  = 2;
   localparam int POS_W   = 7;
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 7;
   localparam int COUNT_W = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [MODE_W-1:0] {
      MODE_FIND   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_DELETE = 2'd2
   } mode_type;

   // Strobes from the sequencer to the word store.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctrl_type;

endpackage

FILE: sv/pal_store.sv
// Word store of the list: one write port and one registered read port.
module pal_store #(
   parameter int DEPTH = pal_pkg::DEPTH_DEFAULT,
   parameter int AW    = 6
) (
   input  logic                           clock,
   input  pal_pkg::store_ctrl_type        ctrl,
   input  logic [AW-1:0]                  rd_addr,
   input  logic [AW-1:0]                  wr_addr,
   input  logic signed [pal_pkg::DATA_W-1:0] wr_data,
   output logic signed [pal_pkg::DATA_W-1:0] rd_data
);
   import pal_pkg::*;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/positional_array_list.sv
// Top level of the positional array list: sequencer, live count and result register.
//
// The block keeps an ordered list of signed 32-bit words in a store of DEPTH
// entries and takes one operation per request word: find reads the entry at a
// position, insert puts a value right after a position (minus one means the
// front) and delete removes the entry at a position. Every request returns
// exactly one response word with a success flag, the value found by a
// successful find (zero otherwise) and the live count after the operation.
// Refused operations (position out of range, insert on a full list, or the
// unused mode code) leave the list unchanged. The list moves its entries
// through a single store with one read port and one write port, so every
// entry that has to shift is first read (ST_MOVE_RD) and then written to
// its new place (ST_MOVE_WR). A new request is accepted while the previous
// response still waits for rsp_ready. The capacity register may be written
// at any time through the csr port, which is always ready; capacities above
// DEPTH act as DEPTH. The store needs no clearing after reset, since only
// entries that were written are ever read.
module positional_array_list #(
   parameter int DEPTH = pal_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pal_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [pal_pkg::POS_W-1:0]  req_position,
   input  logic signed [pal_pkg::DATA_W-1:0] req_item_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_success,
   output logic signed [pal_pkg::DATA_W-1:0] rsp_read_value,
   output logic [pal_pkg::COUNT_W-1:0]       rsp_entry_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pal_pkg::CAP_W-1:0]         csr_capacity
);
   import pal_pkg::*;

   // Address width of the store, width of the live count (which can reach
   // DEPTH itself) and a common width for comparing counts and positions.
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_PLACE,
      ST_REPLY
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CAP_W-1:0]         cap_ff;
   logic [CW-1:0]            cursor_ff, cursor_in;
   logic [CW-1:0]            stop_ff, stop_in;
   logic                     down_ff, down_in;
   logic                     find_ff, find_in;
   logic                     ok_ff, ok_in;
   logic signed [DATA_W-1:0] item_ff, item_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_success_ff, rsp_success_in;
   logic signed [DATA_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic [COUNT_W-1:0]       rsp_entry_count_ff, rsp_entry_count_in;

   logic                     req_take;
   logic                     pos_neg;
   logic                     pos_front;
   logic                     pos_live;
   logic                     list_full;
   logic [XW-1:0]            pos_x;
   logic [XW-1:0]            count_x;
   logic [XW-1:0]            cap_x;
   logic [XW-1:0]            pos_next_x;
   logic [CW-1:0]            neighbor;
   store_ctrl_type           store_ctrl;
   logic [AW-1:0]            rd_addr;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic signed [DATA_W-1:0] rd_data;

   // Range checks on the incoming position; positions and counts are compared in one common width.
   assign pos_neg    = req_position[POS_W-1];
   assign pos_x      = XW'(req_position[POS_W-2:0]);
   assign pos_next_x = pos_x + XW'(1);
   assign count_x    = XW'(count_ff);
   assign cap_x      = XW'(cap_ff);
   assign pos_front  = (req_position == {POS_W{1'b1}});
   assign pos_live   = !pos_neg && (pos_x < count_x);
   assign list_full  = (count_x >= cap_x) || (count_ff == CW'(DEPTH));

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   // The cursor marks the entry being written or found. Its neighbor is
   // the entry that moves into it: the one below for an insert, which walks
   // down from the end, and the one above for a delete, which walks up.
   assign neighbor = down_ff ? (cursor_ff - CW'(1)) : (cursor_ff + CW'(1));

   assign store_ctrl.rd_en = (state_ff == ST_READ) || (state_ff == ST_MOVE_RD);
   assign store_ctrl.wr_en = (state_ff == ST_MOVE_WR) || (state_ff == ST_PLACE);
   assign rd_addr = (state_ff == ST_READ) ? cursor_ff[AW-1:0] : neighbor[AW-1:0];
   assign wr_addr = cursor_ff[AW-1:0];
   assign wr_data = (state_ff == ST_PLACE) ? item_ff : rd_data;

   pal_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_pal_store (
      .clock   (clock),
      .ctrl    (store_ctrl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      cursor_in          = cursor_ff;
      stop_in            = stop_ff;
      down_in            = down_ff;
      find_in            = find_ff;
      ok_in              = ok_ff;
      item_in            = item_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_success_in     = rsp_success_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_entry_count_in = rsp_entry_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               find_in  = 1'b0;
               ok_in    = 1'b0;
               down_in  = 1'b0;
               item_in  = req_item_value;
               state_in = ST_REPLY;
               case (req_mode)
                  MODE_FIND: begin
                     find_in = 1'b1;
                     if (pos_live) begin
                        ok_in     = 1'b1;
                        cursor_in = CW'(pos_x);
                        state_in  = ST_READ;
                     end
                  end
                  MODE_INSERT: begin
                     if ((pos_live || pos_front) && !list_full) begin
                        ok_in     = 1'b1;
                        down_in   = 1'b1;
                        count_in  = count_ff + CW'(1);
                        cursor_in = count_ff;
                        stop_in   = pos_front ? '0 : CW'(pos_next_x);
                        if (count_ff == stop_in) begin
                           state_in = ST_PLACE;
                        end else begin
                           state_in = ST_MOVE_RD;
                        end
                     end
                  end
                  MODE_DELETE: begin
                     if (pos_live) begin
                        ok_in     = 1'b1;
                        count_in  = count_ff - CW'(1);
                        cursor_in = CW'(pos_x);
                        stop_in   = count_ff - CW'(1);
                        if (cursor_in == stop_in) begin
                           state_in = ST_REPLY;
                        end else begin
                           state_in = ST_MOVE_RD;
                        end
                     end
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_REPLY;
         end
         ST_MOVE_RD: begin
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            cursor_in = neighbor;
            if (neighbor != stop_ff) begin
               state_in = ST_MOVE_RD;
            end else if (down_ff) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_PLACE: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            // Wait for the response register to free up, then load it.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_success_in     = ok_ff;
               rsp_read_value_in  = (find_ff && ok_ff) ? rd_data : '0;
               rsp_entry_count_in = count_x[COUNT_W-1:0];
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            cap_ff <= csr_capacity;
         end
      end
      cursor_ff          <= cursor_in;
      stop_ff            <= stop_in;
      down_ff            <= down_in;
      find_ff            <= find_in;
      ok_ff              <= ok_in;
      item_ff            <= item_in;
      rsp_success_ff     <= rsp_success_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

FILE: sv/pal_checker.sv
// Port-level checker of the positional array list and its bind statement.
`include "positional_array_list_assert.svh"

module pal_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_success,
   input logic signed [pal_pkg::DATA_W-1:0] rsp_read_value,
   input logic [pal_pkg::COUNT_W-1:0]       rsp_entry_count
);
   import pal_pkg::*;

   // A response word that is stalled keeps its contents.
   `PAL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_success) && $stable(rsp_entry_count), "stalled response word changed")

   // A refused operation never returns a value.
   `PAL_ASSERT(a_refused_zero, rsp_valid && !rsp_success |-> rsp_read_value == '0, "refused operation returned a nonzero value")

   // The sequencer is busy in the cycle after it takes a request word.
   `PAL_ASSERT(a_busy_after_take, req_valid && req_ready |=> !req_ready, "request taken while previous word in flight")

   // No response word is pending right after reset.
   `PAL_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

bind positional_array_list pal_checker u_pal_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_success     (rsp_success),
   .rsp_read_value  (rsp_read_value),
   .rsp_entry_count (rsp_entry_count)
);

FILE: bench/list_mirror_check.sv
// Checker for the positional array list: mirrors the list and compares every response word.
`timescale 1ns / 100ps

module list_mirror_check #(
   parameter int DEPTH = pal_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [pal_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [pal_pkg::POS_W-1:0]  req_position,
   input  logic signed [pal_pkg::DATA_W-1:0] req_item_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_success,
   input  logic signed [pal_pkg::DATA_W-1:0] rsp_read_value,
   input  logic [pal_pkg::COUNT_W-1:0]       rsp_entry_count,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [pal_pkg::CAP_W-1:0]         csr_capacity,
   output int                                mismatch_count,
   output int                                owed_count,
   output int                                entry_estimate,
   output int                                words_checked,
   output int                                peak_entries,
   output int                                full_refusals
);

   typedef struct packed {
      logic                              success;
      logic signed [pal_pkg::DATA_W-1:0] read_value;
      logic [pal_pkg::COUNT_W-1:0]       entry_count;
   } rsp_word_type;

   logic signed [pal_pkg::DATA_W-1:0] mirror [DEPTH];
   int                                live_entries;
   logic [pal_pkg::CAP_W-1:0]         capacity;
   rsp_word_type                      owed_responses [$];
   int                                errors;
   int                                checked;
   int                                peak;
   int                                refusals;

   // Applies one request word to the mirrored list and returns the response it owes.
   function automatic rsp_word_type apply_list_op(
      input logic [pal_pkg::MODE_W-1:0]        op,
      input int                                pos,
      input logic signed [pal_pkg::DATA_W-1:0] value
   );
      rsp_word_type word;
      int           limit;
      word  = '0;
      limit = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
      case (op)
         pal_pkg::MODE_FIND: begin
            if (pos >= 0 && pos < live_entries) begin
               word.success    = 1'b1;
               word.read_value = mirror[pos];
            end
         end
         pal_pkg::MODE_INSERT: begin
            if (pos >= -1 && pos < live_entries) begin
               if (live_entries >= limit) begin
                  refusals++;
               end else begin
                  for (int j = live_entries - 1; j > pos; j--)
                     mirror[j + 1] = mirror[j];
                  mirror[pos + 1] = value;
                  live_entries++;
                  word.success = 1'b1;
               end
            end
         end
         pal_pkg::MODE_DELETE: begin
            if (pos >= 0 && pos < live_entries) begin
               for (int j = pos + 1; j < live_entries; j++)
                  mirror[j - 1] = mirror[j];
               live_entries--;
               word.success = 1'b1;
            end
         end
         default: ;
      endcase
      word.entry_count = live_entries[pal_pkg::COUNT_W-1:0];
      return word;
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type due;
      if (reset) begin
         foreach (mirror[k])
            mirror[k] = '0;
         live_entries = 0;
         capacity     = pal_pkg::CAP_RESET;
         owed_responses.delete();
         errors   = 0;
         checked  = 0;
         peak     = 0;
         refusals = 0;
      end else begin
         if (csr_valid && csr_ready)
            capacity = csr_capacity;
         if (req_valid && req_ready)
            owed_responses.push_back(apply_list_op(req_mode, int'(req_position),
                                                   req_item_value));
         if (rsp_valid && rsp_ready) begin
            if (owed_responses.size() == 0) begin
               $error("response word arrived while none was awaited");
               errors++;
            end else begin
               due = owed_responses.pop_front();
               checked++;
               if (rsp_success !== due.success) begin
                  $error("success: expected %0d, got %0d", due.success, rsp_success);
                  errors++;
               end
               if (rsp_read_value !== due.read_value) begin
                  $error("read_value: expected %0d, got %0d", due.read_value, rsp_read_value);
                  errors++;
               end
               if (rsp_entry_count !== due.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", due.entry_count,
                         rsp_entry_count);
                  errors++;
               end
            end
         end
         if (live_entries > peak)
            peak = live_entries;
      end
      // Other processes read these at the clock edge, so they change only after it.
      mismatch_count <= errors;
      owed_count     <= owed_responses.size();
      entry_estimate <= live_entries;
      words_checked  <= checked;
      peak_entries   <= peak;
      full_refusals  <= refusals;
   end

endmodule

FILE: bench/tb_positional_array_list.sv
// Testbench top of the positional array list: request stimulus, response pacing and verdict.
`timescale 1ns / 100ps

module tb_positional_array_list;

   localparam int DEPTH           = pal_pkg::DEPTH_DEFAULT;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 150;
   // Long enough for the request side to fill the block and stall.
   localparam int RSP_HOLD_CYCLES = 300;
   // Worst case of one request: an insert at the front of a full list.
   localparam int SETTLE_CYCLES   = 2 * DEPTH + 8;
   // The mode code that the block leaves unused.
   localparam logic [pal_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [pal_pkg::MODE_W-1:0]        req_mode;
   logic signed [pal_pkg::POS_W-1:0]  req_position;
   logic signed [pal_pkg::DATA_W-1:0] req_item_value;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic                              rsp_success;
   logic signed [pal_pkg::DATA_W-1:0] rsp_read_value;
   logic [pal_pkg::COUNT_W-1:0]       rsp_entry_count;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [pal_pkg::CAP_W-1:0]         csr_capacity;

   int mismatch_count;
   int owed_count;
   int entry_estimate;
   int words_checked;
   int peak_entries;
   int full_refusals;

   // Each random phase runs under its own capacity and its own mix of operations.
   // The capacities cover zero, one, the store depth and values above it.
   logic [pal_pkg::CAP_W-1:0] phase_capacity [PHASES] =
      '{7'd127, 7'd64, 7'd0, 7'd5, 7'd64, 7'd1, 7'd100, 7'd64};
   int phase_insert_pct [PHASES] = '{70, 55, 35, 60, 30, 55, 75, 45};

   int   settings_used = 0;
   bit   req_idling;
   logic rsp_idling;
   // Each increment asks the response side for one long hold-off.
   int   hold_ticket = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   positional_array_list #(
      .DEPTH(DEPTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_success     (rsp_success),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity)
   );

   list_mirror_check #(
      .DEPTH(DEPTH)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_success     (rsp_success),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity),
      .mismatch_count  (mismatch_count),
      .owed_count      (owed_count),
      .entry_estimate  (entry_estimate),
      .words_checked   (words_checked),
      .peak_entries    (peak_entries),
      .full_refusals   (full_refusals)
   );

   // Offers one request word and returns at the edge that accepts it. Valid stays
   // high, so the caller either offers the next word or lowers valid.
   task automatic send_word(
      input logic [pal_pkg::MODE_W-1:0]  op,
      input int                          pos,
      input logic [pal_pkg::DATA_W-1:0]  value
   );
      req_valid      <= 1'b1;
      req_mode       <= op;
      req_position   <= pos[pal_pkg::POS_W-1:0];
      req_item_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Lowers valid and waits until every owed response word has come back and the
   // block takes requests again. The owed count is registered and lags behind,
   // which only makes the wait longer.
   task automatic drain_responses;
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_count != 0 || !req_ready);
   endtask

   // Writes the capacity register. Called only while the block is idle.
   task automatic write_capacity(input logic [pal_pkg::CAP_W-1:0] cap);
      csr_valid    <= 1'b1;
      csr_capacity <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // A gap with valid low, taken about one time in four while idling is on.
   task automatic maybe_pause_sender;
      if (req_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Builds one random request word. Most words carry a position that is valid for
   // the current list, so that the list really grows, shrinks and fills up. The rest
   // is noise over every mode code and every position bit. The entry estimate may
   // lag one word behind, which only moves a few positions out of range.
   task automatic random_word(input int insert_pct);
      logic [pal_pkg::MODE_W-1:0] op;
      int                         pos;
      int                         n;
      int                         roll;
      n    = entry_estimate;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         roll = $urandom_range(0, 3);
         op   = roll[pal_pkg::MODE_W-1:0];
         pos  = $urandom_range(0, 127);
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < insert_pct)
            op = pal_pkg::MODE_INSERT;
         else if (roll < insert_pct + (100 - insert_pct) / 2)
            op = pal_pkg::MODE_DELETE;
         else
            op = pal_pkg::MODE_FIND;
         if ($urandom_range(0, 19) == 0)
            pos = $urandom_range(0, 127);
         else if (op == pal_pkg::MODE_INSERT)
            pos = int'($urandom_range(0, n)) - 1;
         else if (n == 0)
            pos = 0;
         else
            pos = $urandom_range(0, n - 1);
      end
      send_word(op, pos, $urandom);
   endtask

   // Response side: random hold-offs while idling is on, and one long hold-off
   // whenever the stimulus asks for it.
   initial begin : rsp_pacing
      int served;
      served = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_ticket != served) begin
            served = hold_ticket;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= pal_pkg::MODE_FIND;
      req_position   <= '0;
      req_item_value <= '0;
      csr_valid      <= 1'b0;
      csr_capacity   <= pal_pkg::CAP_RESET;
      rsp_idling     <= 1'b1;
      req_idling      = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset capacity. Every operation on the empty list is
      // refused, including an insert after position zero.
      send_word(pal_pkg::MODE_FIND,   0, 32'h0000_0000);
      send_word(pal_pkg::MODE_DELETE, 0, 32'h0000_0000);
      send_word(pal_pkg::MODE_INSERT, 0, 32'h1234_5678);
      // Build a short list from the extreme values: at the front, after the last
      // entry and at the front again.
      send_word(pal_pkg::MODE_INSERT, -1, 32'h7FFF_FFFF);
      send_word(pal_pkg::MODE_INSERT, 0, 32'h8000_0000);
      send_word(pal_pkg::MODE_INSERT, -1, 32'hFFFF_FFFF);
      // Insert positions below minus one or past the last entry are refused.
      send_word(pal_pkg::MODE_INSERT, -2, 32'h0000_0005);
      send_word(pal_pkg::MODE_INSERT, -64, 32'h0000_0005);
      send_word(pal_pkg::MODE_INSERT, 63, 32'h0000_0005);
      // Find out of range on both sides, then every live entry.
      send_word(pal_pkg::MODE_FIND, -1, 32'hAAAA_AAAA);
      send_word(pal_pkg::MODE_FIND, 63, 32'hAAAA_AAAA);
      send_word(pal_pkg::MODE_FIND, 0, 32'h0000_0000);
      send_word(pal_pkg::MODE_FIND, 1, 32'h0000_0000);
      send_word(pal_pkg::MODE_FIND, 2, 32'h0000_0000);
      // The unused mode code does nothing and reports the count unchanged.
      send_word(MODE_UNUSED, 0, 32'h5555_5555);
      // Delete in the middle, delete out of range, insert after the last entry and
      // delete at the front.
      send_word(pal_pkg::MODE_DELETE, 1, 32'h0000_0000);
      send_word(pal_pkg::MODE_DELETE, 2, 32'h0000_0000);
      send_word(pal_pkg::MODE_INSERT, 1, 32'h0000_0000);
      send_word(pal_pkg::MODE_DELETE, 0, 32'h0000_0000);

      // A capacity below the live count makes the list full right away.
      drain_responses();
      write_capacity(7'd1);
      send_word(pal_pkg::MODE_INSERT, -1, 32'h0F0F_0F0F);
      send_word(pal_pkg::MODE_DELETE, 1, 32'h0000_0000);
      send_word(pal_pkg::MODE_INSERT, 0, 32'h0F0F_0F0F);

      // With capacity zero the list is always full.
      drain_responses();
      write_capacity(7'd0);
      send_word(pal_pkg::MODE_DELETE, 0, 32'h0000_0000);
      send_word(pal_pkg::MODE_INSERT, -1, 32'h0000_0001);

      // A capacity above the store depth acts as the depth.
      drain_responses();
      write_capacity(7'd127);
      send_word(pal_pkg::MODE_INSERT, -1, 32'h0000_0001);

      // Random phases. Phase 1 holds the response side off for a long stretch while
      // requests keep coming, phase 3 lets every response return halfway through.
      // The sender runs without random gaps in phases 1, 4 and the last one, the
      // response side in phases 4 and the last one.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_responses();
         write_capacity(phase_capacity[ph]);
         req_idling  = (ph != 1 && ph != 4 && ph != PHASES - 1);
         rsp_idling <= (ph != 4 && ph != PHASES - 1);
         if (ph == 1)
            hold_ticket <= hold_ticket + 1;
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            if (ph == 3 && k == WORDS_PER_PHASE / 2)
               drain_responses();
            maybe_pause_sender();
            random_word(phase_insert_pct[ph]);
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d response words under %0d capacity settings, stalls on both sides.",
               words_checked, settings_used);
      $display("The list peaked at %0d entries and refused %0d inserts for lack of room.",
               peak_entries, full_refusals);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Several times the slowest correct run: every insert at the front of a full
   // list with the longest gaps and stalls on both sides.
   initial begin : watchdog
      #15_000_000;
      $display("Timed out waiting for the block.");
      $display("== FAIL ==");
      $finish;
   end

endmodule
